>>> hw/rtl/positional_circular_list_defines.svh
// ----------------------------------------------------------------------------
// positional_circular_list_defines
// Assertion macros shared by the list block; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_CIRCULAR_LIST_DEFINES_SVH
`define POSITIONAL_CIRCULAR_LIST_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define PCL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define PCL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCL_ASSERT_IMP(lbl, ante, cons, msg)
`define PCL_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg
// Sizes, operation and status codes and the cell control bundle of the list.
// ----------------------------------------------------------------------------
package pcl_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 5;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [KIND_W-1:0] {
    K_INS_HEAD = 3'd0,
    K_INS_END  = 3'd1,
    K_DEL_HEAD = 3'd2,
    K_DEL_END  = 3'd3,
    K_INS_POS  = 3'd4,
    K_DEL_POS  = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

>>> hw/rtl/pcl_cell.sv
// ----------------------------------------------------------------------------
// pcl_cell
// One list slot: holds an entry, shifts right on insert, left on delete.
// ----------------------------------------------------------------------------
module pcl_cell (
  input  logic                       clk,
  input  pcl_pkg::cell_ctl_t         ctl,
  input  logic [pcl_pkg::IDX_W-1:0]  my_idx,
  input  logic [pcl_pkg::VAL_W-1:0]  left_data,
  input  logic [pcl_pkg::VAL_W-1:0]  right_data,
  input  logic [pcl_pkg::VAL_W-1:0]  acc_in,
  output logic [pcl_pkg::VAL_W-1:0]  data_out,
  output logic [pcl_pkg::VAL_W-1:0]  acc_out
);
  import pcl_pkg::*;

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (my_idx == ctl.idx) begin
        data_nxt = ctl.value;
      end else if (my_idx > ctl.idx) begin
        data_nxt = left_data;
      end
    end else if (ctl.del) begin
      if (my_idx >= ctl.idx) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // removed entry travels along the chain as an or-accumulation
  assign acc_out  = acc_in | ((ctl.del && (my_idx == ctl.idx)) ? data_r : '0);
  assign data_out = data_r;

endmodule

>>> hw/rtl/pcl_ctrl.sv
// ----------------------------------------------------------------------------
// pcl_ctrl
// Entry counter and operation decode: status, target slot, cell commands.
// ----------------------------------------------------------------------------
module pcl_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [pcl_pkg::KIND_W-1:0]  kind,
  input  logic [pcl_pkg::VAL_W-1:0]   value,
  input  logic [pcl_pkg::POS_W-1:0]   position,
  output pcl_pkg::cell_ctl_t          ctl,
  output pcl_pkg::status_t            status,
  output logic [pcl_pkg::CNT_W-1:0]   count_nxt,
  output logic [pcl_pkg::CNT_W-1:0]   count_q
);
  import pcl_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CMP_W-1:0] n_w;
  logic [CMP_W-1:0] pos_w;
  logic             full;
  logic             empty;
  logic             ins_ok;
  logic             del_ok;
  logic [IDX_W-1:0] idx;

  assign n_w   = CMP_W'(count_r);
  assign pos_w = CMP_W'(position);
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  always_comb begin
    status = ST_OK;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    idx    = '0;
    case (kind)
      K_INS_HEAD: begin
        if (full) status = ST_FULL;
        else ins_ok = 1'b1;
      end
      K_INS_END: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ins_ok = 1'b1;
          idx    = IDX_W'(count_r);
        end
      end
      K_INS_POS: begin
        if (full) begin
          status = ST_FULL;
        end else if ((pos_w == '0) || (pos_w > n_w + CMP_W'(1))) begin
          status = ST_RANGE;
        end else begin
          ins_ok = 1'b1;
          idx    = IDX_W'(pos_w - CMP_W'(1));
        end
      end
      K_DEL_HEAD: begin
        if (empty) status = ST_EMPTY;
        else del_ok = 1'b1;
      end
      K_DEL_END: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          del_ok = 1'b1;
          idx    = IDX_W'(n_w - CMP_W'(1));
        end
      end
      K_DEL_POS: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if ((pos_w == '0) || (pos_w > n_w)) begin
          status = ST_RANGE;
        end else begin
          del_ok = 1'b1;
          idx    = IDX_W'(pos_w - CMP_W'(1));
        end
      end
      default: begin
        // undefined kinds leave the list alone
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) count_nxt = count_r + CNT_W'(1);
    else if (del_ok) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

  assign ctl.ins   = fire && ins_ok;
  assign ctl.del   = fire && del_ok;
  assign ctl.idx   = idx;
  assign ctl.value = value;
  assign count_q   = count_r;

endmodule

>>> hw/rtl/positional_circular_list.sv
// ----------------------------------------------------------------------------
// positional_circular_list
// Bounded ordered list of signed 32-bit entries with head, end and
// positional insert and delete.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one operation (kind on in_tuser, value and
// 1-based position on in_tdata). Each accepted beat yields exactly one
// output beat with the status on out_tuser, the removed value and the entry
// count after the step on out_tdata.
// out_tvalid rises in the cycle after input acceptance. Throughput is one
// beat per cycle while the receiver takes results: the whole operation is done
// by a row of CAPACITY cells, each shifting its entry from a neighbor, while the
// removed entry is gathered along the same row.
// The output register frees as it is taken, so a new beat is accepted in
// the cycle the pending result leaves. When the receiver stalls, in_tready
// drops and the held result stays unchanged.
// Reset empties the list (entry count zero) and clears out_tvalid; the cell
// contents are not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
module positional_circular_list (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [36:32] position, [39:37] zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] removed_value, [36:32] entry_count
  output logic [1:0]  out_tuser   // [1:0] status
);
  import pcl_pkg::*;

  `include "positional_circular_list_defines.svh"

  logic               fire;
  cell_ctl_t          ctl;
  status_t            status;
  logic [CNT_W-1:0]   count_nxt;
  logic [CNT_W-1:0]   count_q;
  logic [VAL_W-1:0]   cell_data [CAPACITY];
  logic [VAL_W-1:0]   cell_acc  [CAPACITY];

  logic               out_valid_r;
  logic               out_valid_nxt;
  status_t            out_status_r;
  logic [VAL_W-1:0]   out_removed_r;
  logic [ECNT_W-1:0]  out_count_r;

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  pcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .kind      (in_tuser[KIND_W-1:0]),
    .value     (in_tdata[VAL_W-1:0]),
    .position  (in_tdata[VAL_W+POS_W-1:VAL_W]),
    .ctl       (ctl),
    .status    (status),
    .count_nxt (count_nxt),
    .count_q   (count_q)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pcl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .my_idx     (IDX_W'(i)),
      .left_data  ((i == 0) ? ctl.value : cell_data[(i == 0) ? 0 : i-1]),
      .right_data ((i == CAPACITY-1) ? cell_data[i]
                                     : cell_data[(i == CAPACITY-1) ? i : i+1]),
      .acc_in     ((i == 0) ? '0 : cell_acc[(i == 0) ? 0 : i-1]),
      .data_out   (cell_data[i]),
      .acc_out    (cell_acc[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r  <= status;
      out_removed_r <= cell_acc[CAPACITY-1];
      out_count_r   <= ECNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_count_r, out_removed_r};

  `PCL_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY),
                  "entry count above capacity")
  `PCL_ASSERT_NXT(a_ins_grows, ctl.ins, count_q == $past(count_q) + CNT_W'(1),
                  "insert did not grow the list by one")
  `PCL_ASSERT_IMP(a_full_only_at_cap, fire && (status == ST_FULL),
                  count_q == CNT_W'(CAPACITY), "full reported below capacity")
  `PCL_ASSERT_IMP(a_removed_zero, out_valid_r && (out_status_r != ST_OK),
                  out_removed_r == '0, "removed value set on a failed step")

endmodule

>>> tb/pcl_result_check.sv
// ----------------------------------------------------------------------------
// pcl_result_check
// Watches both stream channels of the list block. Every accepted input beat
// is run through a shadow copy of the list to get the expected status,
// removed value and entry count. Every output beat is compared field by field
// with the oldest expected result. Mismatches and pending results are
// reported to the testbench top.
// ----------------------------------------------------------------------------
module pcl_result_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [36:32] position, [39:37] zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] removed_value, [36:32] entry_count
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          bad_results,
  output int          results_pending
);
  import pcl_pkg::*;

  typedef struct {
    status_t           status;
    logic [VAL_W-1:0]  removed;
    logic [ECNT_W-1:0] count;
  } list_result_t;

  list_result_t     results_due[$];
  logic [VAL_W-1:0] mirror_cells [CAPACITY];
  int               mirror_count;

  function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] kind,
                                                 input logic [VAL_W-1:0]  value,
                                                 input logic [POS_W-1:0]  pos);
    list_result_t r;
    int           slot;
    int           i;
    r.status  = ST_OK;
    r.removed = '0;
    slot      = 0;
    case (kind)
      K_INS_HEAD, K_INS_END, K_INS_POS: begin
        // full is checked ahead of the position range
        if (mirror_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (kind == K_INS_POS && (pos == 0 || pos > mirror_count + 1)) begin
          r.status = ST_RANGE;
        end else begin
          if (kind == K_INS_END) begin
            slot = mirror_count;
          end else if (kind == K_INS_POS) begin
            slot = int'(pos) - 1;
          end
          for (i = mirror_count; i > slot; i--) mirror_cells[i] = mirror_cells[i-1];
          mirror_cells[slot] = value;
          mirror_count++;
        end
      end
      K_DEL_HEAD, K_DEL_END, K_DEL_POS: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else if (kind == K_DEL_POS && (pos == 0 || pos > mirror_count)) begin
          r.status = ST_RANGE;
        end else begin
          if (kind == K_DEL_END) begin
            slot = mirror_count - 1;
          end else if (kind == K_DEL_POS) begin
            slot = int'(pos) - 1;
          end
          r.removed = mirror_cells[slot];
          for (i = slot; i < mirror_count - 1; i++) mirror_cells[i] = mirror_cells[i+1];
          mirror_count--;
        end
      end
      default: ;  // spare kinds leave the list alone
    endcase
    r.count = ECNT_W'(mirror_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t due;
    if (!rst_n) begin
      results_due.delete();
      mirror_count = 0;
      results_pending <= 0;
    end else begin
      // compare before pushing so a stray beat never meets a fresh expectation
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $error("result beat with none expected: status %0d removed %0d count %0d",
                 out_tuser, $signed(out_tdata[31:0]), out_tdata[36:32]);
          bad_results++;
        end else begin
          due = results_due.pop_front();
          if (out_tuser !== due.status) begin
            $error("status expected %0d actual %0d", due.status, out_tuser);
            bad_results++;
          end
          if (out_tdata[31:0] !== due.removed) begin
            $error("removed_value expected %0d actual %0d",
                   $signed(due.removed), $signed(out_tdata[31:0]));
            bad_results++;
          end
          if (out_tdata[36:32] !== due.count) begin
            $error("entry_count expected %0d actual %0d", due.count, out_tdata[36:32]);
            bad_results++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        results_due.push_back(apply_list_op(in_tuser, in_tdata[31:0], in_tdata[36:32]));
      end
      results_pending <= results_due.size();
    end
  end

endmodule

>>> tb/positional_circular_list_test.sv
// ----------------------------------------------------------------------------
// positional_circular_list_test
// Drives head, end and positional inserts and deletes into the list block,
// first a directed pass over empty, full and out-of-range cases, then random
// bursts that swing the list between empty and full under several idle and
// stall patterns, including a long output hold that backs up the input.
// ----------------------------------------------------------------------------
module positional_circular_list_test;
  import pcl_pkg::*;

  localparam logic [KIND_W-1:0] K_SPARE_LO  = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE_HI  = 3'd7;
  localparam logic [VAL_W-1:0]  VAL_MAX     = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]  VAL_MIN     = 32'h8000_0000;
  localparam int                HOLD_CYCLES = 400;
  localparam int                STALL_LIMIT = 4000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  int bad_results;
  int results_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;

  always #10 clk = ~clk;

  positional_circular_list DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  pcl_result_check result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .bad_results     (bad_results),
    .results_pending (results_pending)
  );

  // output side: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value,
                         input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, pos, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    // pending count is registered, so let it settle past the next edge first
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
    int                sent;
    int                burst_left;
    int                pick;
    bit                growing;
    bit                do_ins;
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  pos;
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    sent       = 0;
    burst_left = 0;
    growing    = 1'b0;
    while (sent < items) begin
      // bursts lean toward inserts or deletes so the list swings full and empty
      if (burst_left == 0) begin
        growing    = !growing;
        burst_left = $urandom_range(40, 8);
      end
      burst_left--;
      pick   = $urandom_range(99);
      do_ins = (pick < 72) ? growing : !growing;
      if (pick < 2) begin
        kind = K_SPARE_LO;
      end else if (pick < 4) begin
        kind = K_SPARE_HI;
      end else begin
        case ($urandom_range(2))
          0:       kind = do_ins ? K_INS_HEAD : K_DEL_HEAD;
          1:       kind = do_ins ? K_INS_END : K_DEL_END;
          default: kind = do_ins ? K_INS_POS : K_DEL_POS;
        endcase
      end
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       value = VAL_MIN;
          1:       value = VAL_MAX;
          2:       value = '0;
          default: value = '1;
        endcase
      end else begin
        value = $urandom;
      end
      pos = ($urandom_range(9) == 0) ? POS_W'($urandom_range(31))
                                     : POS_W'($urandom_range(17, 1));
      send_op(kind, value, pos);
      if (kind <= K_DEL_POS) sent++;
    end
    wait_drained();
  endtask

  initial begin : stimulus
    int i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: deletes report empty before any range check
    send_op(K_DEL_HEAD, 32'h1234_5678, 5'd1);
    send_op(K_DEL_END, 32'h0, 5'd1);
    send_op(K_DEL_POS, 32'h0, 5'd1);
    send_op(K_INS_POS, 32'h5555_5555, 5'd2);
    send_op(K_INS_POS, 32'hAAAA_AAAA, 5'd0);
    send_op(K_INS_HEAD, VAL_MAX, 5'd0);
    send_op(K_INS_END, VAL_MIN, 5'd31);
    send_op(K_INS_POS, '1, 5'd2);
    send_op(K_INS_POS, '0, 5'd4);
    send_op(K_DEL_POS, 32'h0, 5'd0);
    send_op(K_DEL_POS, 32'h0, 5'd31);
    send_op(K_DEL_POS, 32'h0, 5'd5);
    send_op(K_SPARE_LO, $urandom, POS_W'($urandom_range(31)));
    send_op(K_SPARE_HI, $urandom, POS_W'($urandom_range(31)));
    // fill to capacity
    for (i = 0; i < CAPACITY - 4; i++) begin
      case (i % 3)
        0:       send_op(K_INS_HEAD, $urandom, 5'd0);
        1:       send_op(K_INS_END, $urandom, 5'd0);
        default: send_op(K_INS_POS, $urandom, 5'd3);
      endcase
    end
    // full list: inserts report full before any range check
    send_op(K_INS_HEAD, 32'h0BAD_0001, 5'd1);
    send_op(K_INS_POS, 32'h0BAD_0002, 5'd31);
    send_op(K_DEL_POS, 32'h0, 5'd16);
    send_op(K_DEL_POS, 32'h0, 5'd16);
    send_op(K_DEL_POS, 32'h0, 5'd2);
    send_op(K_DEL_END, 32'h0, 5'd0);
    send_op(K_DEL_HEAD, 32'h0, 5'd0);
    wait_drained();

    // long output hold while the sender keeps offering beats
    hold_requests <= hold_requests + 1;
    run_phase(40, 0, 0);

    run_phase(125, 0, 0);
    run_phase(125, 87, 0);
    run_phase(125, 0, 87);
    run_phase(125, 20, 20);

    repeat (4) @(posedge clk);
    if (bad_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pcl_pkg.sv
hw/rtl/pcl_cell.sv
hw/rtl/pcl_ctrl.sv
hw/rtl/positional_circular_list.sv
tb/pcl_result_check.sv
tb/positional_circular_list_test.sv
